// ===== src/rotor_cipher_machine_unit_defines.svh =====
// assertion macros for the rotor cipher machine unit
// no dependencies; included by the files that carry assertions
`ifndef ROTOR_CIPHER_MACHINE_UNIT_DEFINES_SVH
`define ROTOR_CIPHER_MACHINE_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define RCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/rcm_pkg.sv =====
// shared types, constants, microcode rom and modulo-26 helpers
// for the rotor cipher machine; no dependencies
package rcm_pkg;

    // alphabet and sizing
    localparam int ALPHA      = 26;
    localparam int LAST       = ALPHA - 1;
    localparam int MAX_ROTORS = 8;
    localparam int LW         = 5;
    localparam int CW         = 4;
    localparam int IW         = 3;
    localparam int JW         = $clog2(MAX_ROTORS + 1);
    localparam int RW         = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int WDEPTH     = MAX_ROTORS * ALPHA;
    localparam int AW         = $clog2(WDEPTH);
    localparam int UW         = (JW > CW) ? JW : CW;
    localparam logic [CW-1:0] COUNT_RESET = 4'd3;

    // action codes
    localparam logic [2:0] ACT_ENCRYPT  = 3'd0;
    localparam logic [2:0] ACT_PLUG_SWP = 3'd1;
    localparam logic [2:0] ACT_WIRE_WR  = 3'd2;
    localparam logic [2:0] ACT_SET_POS  = 3'd3;
    localparam logic [2:0] ACT_REFL_WR  = 3'd4;
    localparam logic [2:0] ACT_PLUG_RST = 3'd5;

    // microprogram addresses
    localparam int PCW = 5;
    typedef logic [PCW-1:0] t_pc;
    localparam t_pc PC_IDLE   = 5'd0;
    localparam t_pc PC_E_STEP = 5'd1;
    localparam t_pc PC_E_PB   = 5'd2;
    localparam t_pc PC_E_PBX  = 5'd3;
    localparam t_pc PC_E_FRD  = 5'd4;
    localparam t_pc PC_E_FX   = 5'd5;
    localparam t_pc PC_E_REFL = 5'd6;
    localparam t_pc PC_E_BRD  = 5'd7;
    localparam t_pc PC_E_BX   = 5'd8;
    localparam t_pc PC_E_PB2  = 5'd9;
    localparam t_pc PC_E_EMIT = 5'd10;
    localparam t_pc PC_S_RDA  = 5'd11;
    localparam t_pc PC_S_RDB  = 5'd12;
    localparam t_pc PC_S_WRA  = 5'd13;
    localparam t_pc PC_S_WRB  = 5'd14;
    localparam t_pc PC_W_WR   = 5'd15;
    localparam t_pc PC_P_WR   = 5'd16;
    localparam t_pc PC_R_WR   = 5'd17;
    localparam t_pc PC_C_CLR  = 5'd18;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_STEP,
        OP_PB_RD_A,
        OP_X_PB,
        OP_INV_RD,
        OP_X_INV,
        OP_X_REFL,
        OP_WIR_RD,
        OP_X_WIR,
        OP_PB_RD_X,
        OP_EMIT,
        OP_PB_RD_B,
        OP_PB_WR_A,
        OP_PB_WR_B,
        OP_WIRE_WR,
        OP_POS_WR,
        OP_REFL_WR,
        OP_PB_CLR
    } t_op;

    // sequencing modes
    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_DISPATCH,
        C_BR_T,
        C_BR_F,
        C_HOLD
    } t_cond;

    // status flag select
    typedef enum logic [2:0] {
        F_WRAP,
        F_FWD,
        F_FWD_NEXT,
        F_BACK,
        F_BACK_NEXT,
        F_BUSY
    } t_flag;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_flag flag;
        t_pc   target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic load;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic wrap;
        logic fwd;
        logic fwd_next;
        logic back;
        logic back_next;
        logic out_busy;
    } t_stat;

    // control store
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            PC_IDLE:   w = '{OP_NOP,     C_DISPATCH, F_WRAP,      PC_IDLE};
            PC_E_STEP: w = '{OP_STEP,    C_HOLD,     F_WRAP,      PC_E_PB};
            PC_E_PB:   w = '{OP_PB_RD_A, C_NEXT,     F_WRAP,      PC_IDLE};
            PC_E_PBX:  w = '{OP_X_PB,    C_BR_F,     F_FWD,       PC_E_REFL};
            PC_E_FRD:  w = '{OP_INV_RD,  C_NEXT,     F_WRAP,      PC_IDLE};
            PC_E_FX:   w = '{OP_X_INV,   C_BR_T,     F_FWD_NEXT,  PC_E_FRD};
            PC_E_REFL: w = '{OP_X_REFL,  C_BR_F,     F_BACK,      PC_E_PB2};
            PC_E_BRD:  w = '{OP_WIR_RD,  C_NEXT,     F_WRAP,      PC_IDLE};
            PC_E_BX:   w = '{OP_X_WIR,   C_BR_T,     F_BACK_NEXT, PC_E_BRD};
            PC_E_PB2:  w = '{OP_PB_RD_X, C_NEXT,     F_WRAP,      PC_IDLE};
            PC_E_EMIT: w = '{OP_EMIT,    C_HOLD,     F_BUSY,      PC_IDLE};
            PC_S_RDA:  w = '{OP_PB_RD_A, C_NEXT,     F_WRAP,      PC_IDLE};
            PC_S_RDB:  w = '{OP_PB_RD_B, C_NEXT,     F_WRAP,      PC_IDLE};
            PC_S_WRA:  w = '{OP_PB_WR_A, C_NEXT,     F_WRAP,      PC_IDLE};
            PC_S_WRB:  w = '{OP_PB_WR_B, C_GOTO,     F_WRAP,      PC_IDLE};
            PC_W_WR:   w = '{OP_WIRE_WR, C_GOTO,     F_WRAP,      PC_IDLE};
            PC_P_WR:   w = '{OP_POS_WR,  C_GOTO,     F_WRAP,      PC_IDLE};
            PC_R_WR:   w = '{OP_REFL_WR, C_GOTO,     F_WRAP,      PC_IDLE};
            PC_C_CLR:  w = '{OP_PB_CLR,  C_GOTO,     F_WRAP,      PC_IDLE};
            default:   w = '{OP_NOP,     C_GOTO,     F_WRAP,      PC_IDLE};
        endcase
        return w;
    endfunction

    // entry point of each action
    function automatic t_pc dispatch(input logic [2:0] action);
        t_pc pc;
        case (action)
            ACT_ENCRYPT:  pc = PC_E_STEP;
            ACT_PLUG_SWP: pc = PC_S_RDA;
            ACT_WIRE_WR:  pc = PC_W_WR;
            ACT_SET_POS:  pc = PC_P_WR;
            ACT_REFL_WR:  pc = PC_R_WR;
            ACT_PLUG_RST: pc = PC_C_CLR;
            default:      pc = PC_IDLE;
        endcase
        return pc;
    endfunction

    // fold a 5-bit value into the alphabet
    function automatic logic [LW-1:0] mod26(input logic [LW-1:0] v);
        return (v >= LW'(ALPHA)) ? LW'(v - LW'(ALPHA)) : v;
    endfunction

    // (a + b) mod 26 for a, b below 26
    function automatic logic [LW-1:0] add26(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= (LW+1)'(ALPHA)) ? LW'(s - (LW+1)'(ALPHA)) : LW'(s);
    endfunction

    // (a - b) mod 26 for a, b below 26
    function automatic logic [LW-1:0] sub26(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + (LW+1)'(ALPHA) - {1'b0, b};
        return (s >= (LW+1)'(ALPHA)) ? LW'(s - (LW+1)'(ALPHA)) : LW'(s);
    endfunction

    // flat wiring table address of rotor r, entry e
    function automatic logic [AW-1:0] waddr(input logic [RW-1:0] r, input logic [LW-1:0] e);
        return AW'(AW'(r) * AW'(ALPHA)) + AW'(e);
    endfunction

endpackage

// ===== src/rotor_cipher_machine_unit.sv =====
// encrypt: the rotors step, holding while a carry moves on, then each rotor in use gets one
// registered table read and one compute step each way, forward through the inverse wiring
// memory and back through the wiring memory; the emit step holds while the result is busy
// loads: plug swap reads both entries, then writes both; one request at a time
// reset: plugboard identity, positions zero, rotor count 3; no clearing pass
`include "rotor_cipher_machine_unit_defines.svh"
// top level: stream ports, sequencer and datapath; depends on rcm_pkg
module rotor_cipher_machine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // rotor_index[2:0], entry_index[7:3], letter[12:8], second_letter[17:13]
    input  logic [23:0] i_s_tdata,
    // action[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cipher_letter[4:0]
    output logic [7:0]  o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    rcm_pkg::t_ctrl              w_ctrl;
    rcm_pkg::t_stat              w_stat;
    logic                        w_accept;
    logic                        w_ready;
    logic [rcm_pkg::LW-1:0]      w_letter;

    assign w_accept    = i_s_tvalid && w_ready;
    assign o_s_tready  = w_ready;
    assign o_cfg_ready = 1'b1;

    // control
    rcm_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_action (i_s_tuser),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl),
        .o_ready  (w_ready)
    );

    // datapath
    rcm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_rotor_index   (i_s_tdata[2:0]),
        .i_entry_index   (i_s_tdata[7:3]),
        .i_letter        (i_s_tdata[12:8]),
        .i_second_letter (i_s_tdata[17:13]),
        .i_cfg_wr        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_m_tready),
        .o_stat          (w_stat),
        .o_out_valid     (o_m_tvalid),
        .o_out_letter    (w_letter)
    );

    assign o_m_tdata = {3'b000, w_letter};

    // checks
    `RCM_ASSERT_IMPL(a_idle_no_op, i_clk, i_rst_n, w_ready, w_ctrl.op == rcm_pkg::OP_NOP, "datapath op while idle")
    `RCM_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, (w_ctrl.op == rcm_pkg::OP_EMIT) && !w_stat.out_busy, o_m_tvalid, "result not loaded")
    `RCM_ASSERT_NEXT(a_encrypt_busy, i_clk, i_rst_n, w_accept && (i_s_tuser == rcm_pkg::ACT_ENCRYPT), !o_s_tready, "ready during encrypt")

endmodule

// ===== src/rcm_sequencer.sv =====
// microcode sequencer: step counter, control store lookup and branching
// depends on rcm_pkg
module rcm_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_action,
    input  rcm_pkg::t_stat   i_stat,
    output rcm_pkg::t_ctrl   o_ctrl,
    output logic             o_ready
);

    rcm_pkg::t_pc    r_pc;
    rcm_pkg::t_pc    n_pc;
    rcm_pkg::t_uword w_uw;
    logic            w_flag;

    assign w_uw = rcm_pkg::ucode(r_pc);

    // flag select
    always_comb begin
        case (w_uw.flag)
            rcm_pkg::F_WRAP:      w_flag = i_stat.wrap;
            rcm_pkg::F_FWD:       w_flag = i_stat.fwd;
            rcm_pkg::F_FWD_NEXT:  w_flag = i_stat.fwd_next;
            rcm_pkg::F_BACK:      w_flag = i_stat.back;
            rcm_pkg::F_BACK_NEXT: w_flag = i_stat.back_next;
            rcm_pkg::F_BUSY:      w_flag = i_stat.out_busy;
            default:              w_flag = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        case (w_uw.cond)
            rcm_pkg::C_NEXT:     n_pc = rcm_pkg::PCW'(r_pc + 1'b1);
            rcm_pkg::C_GOTO:     n_pc = w_uw.target;
            rcm_pkg::C_DISPATCH: n_pc = i_accept ? rcm_pkg::dispatch(i_action) : r_pc;
            rcm_pkg::C_BR_T:     n_pc = w_flag ? w_uw.target : rcm_pkg::PCW'(r_pc + 1'b1);
            rcm_pkg::C_BR_F:     n_pc = w_flag ? rcm_pkg::PCW'(r_pc + 1'b1) : w_uw.target;
            rcm_pkg::C_HOLD:     n_pc = w_flag ? r_pc : w_uw.target;
            default:             n_pc = rcm_pkg::PC_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rcm_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ready     = (r_pc == rcm_pkg::PC_IDLE);
    assign o_ctrl.op   = w_uw.op;
    assign o_ctrl.load = i_accept;

endmodule

// ===== src/rcm_datapath.sv =====
// datapath: plugboard, rotor tables, reflector, positions, letter register
// and result register; depends on rcm_pkg
module rcm_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rcm_pkg::t_ctrl               i_ctrl,
    input  logic [rcm_pkg::IW-1:0]       i_rotor_index,
    input  logic [rcm_pkg::LW-1:0]       i_entry_index,
    input  logic [rcm_pkg::LW-1:0]       i_letter,
    input  logic [rcm_pkg::LW-1:0]       i_second_letter,
    input  logic                         i_cfg_wr,
    input  logic [rcm_pkg::CW-1:0]       i_cfg_data,
    input  logic                         i_out_ready,
    output rcm_pkg::t_stat               o_stat,
    output logic                         o_out_valid,
    output logic [rcm_pkg::LW-1:0]       o_out_letter
);

    localparam int LW = rcm_pkg::LW;
    localparam int JW = rcm_pkg::JW;
    localparam int RW = rcm_pkg::RW;
    localparam int AW = rcm_pkg::AW;
    localparam int UW = rcm_pkg::UW;

    // control state
    logic [rcm_pkg::CW-1:0] r_count;
    logic [JW-1:0]          r_j;
    logic [LW-1:0]          r_pos [rcm_pkg::MAX_ROTORS];
    logic                   r_pb_vld [rcm_pkg::ALPHA];
    logic                   r_out_valid;

    // payload
    logic [rcm_pkg::IW-1:0] r_rotor;
    logic [LW-1:0]          r_entry;
    logic [LW-1:0]          r_a;
    logic [LW-1:0]          r_b;
    logic [LW-1:0]          r_x;
    logic [LW-1:0]          r_tmp;
    logic [LW-1:0]          r_out_letter;
    logic [LW-1:0]          r_refl [rcm_pkg::ALPHA];

    // memories
    logic [LW-1:0]          r_pb_mem [rcm_pkg::ALPHA];
    logic [LW-1:0]          r_pb_q;
    logic                   r_pb_hit;
    logic [LW-1:0]          r_pb_raddr;
    logic [LW-1:0]          r_wir_mem [rcm_pkg::WDEPTH];
    logic [LW-1:0]          r_inv_mem [rcm_pkg::WDEPTH];
    logic [LW-1:0]          r_wir_q;
    logic [LW-1:0]          r_inv_q;

    logic [JW-1:0]          w_used;
    logic [RW-1:0]          w_idx;
    logic [LW-1:0]          w_p;
    logic [LW-1:0]          w_xp;
    logic [LW-1:0]          w_pb_val;
    logic                   w_j_lt_used;
    logic                   w_rotor_ok;
    logic                   w_out_busy;
    logic                   w_pb_rd;
    logic [LW-1:0]          w_pb_ra;
    logic                   w_pb_wr;
    logic [LW-1:0]          w_pb_wa;
    logic [LW-1:0]          w_pb_wd;
    logic [AW-1:0]          w_taddr;

    // rotors in use, limited to the built count
    assign w_used = (UW'(r_count) < UW'(rcm_pkg::MAX_ROTORS)) ?
                    JW'(r_count) : JW'(rcm_pkg::MAX_ROTORS);
    assign w_j_lt_used = (r_j < w_used);
    assign w_rotor_ok  = ((JW+1)'(r_rotor) < (JW+1)'(rcm_pkg::MAX_ROTORS));

    // backward pass addresses rotor j-1
    always_comb begin
        if (i_ctrl.op == rcm_pkg::OP_WIR_RD || i_ctrl.op == rcm_pkg::OP_X_WIR) begin
            w_idx = RW'(r_j - 1'b1);
        end else begin
            w_idx = RW'(r_j);
        end
    end

    assign w_p      = r_pos[w_idx];
    assign w_xp     = rcm_pkg::add26(r_x, w_p);
    assign w_taddr  = rcm_pkg::waddr(w_idx, w_xp);
    assign w_pb_val = r_pb_hit ? r_pb_q : r_pb_raddr;
    assign w_out_busy = r_out_valid && !i_out_ready;

    // status to sequencer
    assign o_stat.wrap      = w_j_lt_used && (w_p == LW'(rcm_pkg::LAST));
    assign o_stat.fwd       = w_j_lt_used;
    assign o_stat.fwd_next  = ({1'b0, r_j} + 1'b1) < {1'b0, w_used};
    assign o_stat.back      = (r_j != '0);
    assign o_stat.back_next = (r_j > JW'(1));
    assign o_stat.out_busy  = w_out_busy;

    // plugboard port selection
    always_comb begin
        w_pb_rd = (i_ctrl.op inside {rcm_pkg::OP_PB_RD_A, rcm_pkg::OP_PB_RD_B,
                                     rcm_pkg::OP_PB_RD_X});
        case (i_ctrl.op)
            rcm_pkg::OP_PB_RD_B: w_pb_ra = r_b;
            rcm_pkg::OP_PB_RD_X: w_pb_ra = r_x;
            default:             w_pb_ra = r_a;
        endcase
        w_pb_wr = (i_ctrl.op inside {rcm_pkg::OP_PB_WR_A, rcm_pkg::OP_PB_WR_B});
        if (i_ctrl.op == rcm_pkg::OP_PB_WR_B) begin
            w_pb_wa = r_b;
            w_pb_wd = r_tmp;
        end else begin
            w_pb_wa = r_a;
            w_pb_wd = w_pb_val;
        end
    end

    // plugboard memory, unwritten entries read as identity
    always_ff @(posedge i_clk) begin
        if (w_pb_rd) begin
            r_pb_q     <= r_pb_mem[w_pb_ra];
            r_pb_hit   <= r_pb_vld[w_pb_ra];
            r_pb_raddr <= w_pb_ra;
        end
        if (w_pb_wr) begin
            r_pb_mem[w_pb_wa] <= w_pb_wd;
        end
    end

    // plugboard valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.op == rcm_pkg::OP_PB_CLR) begin
            for (int i = 0; i < rcm_pkg::ALPHA; i++) begin
                r_pb_vld[i] <= 1'b0;
            end
        end else if (w_pb_wr) begin
            r_pb_vld[w_pb_wa] <= 1'b1;
        end
    end

    // rotor wiring memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == rcm_pkg::OP_WIR_RD) begin
            r_wir_q <= r_wir_mem[w_taddr];
        end
        if (i_ctrl.op == rcm_pkg::OP_WIRE_WR && w_rotor_ok) begin
            r_wir_mem[rcm_pkg::waddr(RW'(r_rotor), r_entry)] <= r_a;
        end
    end

    // inverse wiring memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == rcm_pkg::OP_INV_RD) begin
            r_inv_q <= r_inv_mem[w_taddr];
        end
        if (i_ctrl.op == rcm_pkg::OP_WIRE_WR && w_rotor_ok) begin
            r_inv_mem[rcm_pkg::waddr(RW'(r_rotor), r_a)] <= r_entry;
        end
    end

    // request fields, letter register, swap holding register, reflector
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rotor <= i_rotor_index;
            r_entry <= rcm_pkg::mod26(i_entry_index);
            r_a     <= rcm_pkg::mod26(i_letter);
            r_b     <= rcm_pkg::mod26(i_second_letter);
        end
        case (i_ctrl.op)
            rcm_pkg::OP_X_PB:    r_x <= w_pb_val;
            rcm_pkg::OP_X_INV:   r_x <= rcm_pkg::sub26(r_inv_q, w_p);
            rcm_pkg::OP_X_REFL:  r_x <= r_refl[r_x];
            rcm_pkg::OP_X_WIR:   r_x <= rcm_pkg::sub26(r_wir_q, w_p);
            rcm_pkg::OP_PB_RD_B: r_tmp <= w_pb_val;
            rcm_pkg::OP_REFL_WR: r_refl[r_a] <= r_entry;
            default: ;
        endcase
    end

    // rotor counter, positions and rotor count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= rcm_pkg::COUNT_RESET;
            r_j     <= '0;
            for (int i = 0; i < rcm_pkg::MAX_ROTORS; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            if (i_cfg_wr) begin
                r_count <= i_cfg_data;
            end
            if (i_ctrl.load) begin
                r_j <= '0;
            end else begin
                case (i_ctrl.op)
                    // odometer step, carry moves on to the next rotor
                    rcm_pkg::OP_STEP: begin
                        if (w_j_lt_used) begin
                            if (w_p == LW'(rcm_pkg::LAST)) begin
                                r_pos[w_idx] <= '0;
                                r_j          <= JW'(r_j + 1'b1);
                            end else begin
                                r_pos[w_idx] <= LW'(w_p + 1'b1);
                            end
                        end
                    end
                    rcm_pkg::OP_PB_RD_A: r_j <= '0;
                    rcm_pkg::OP_X_INV:   r_j <= JW'(r_j + 1'b1);
                    rcm_pkg::OP_X_WIR:   r_j <= JW'(r_j - 1'b1);
                    rcm_pkg::OP_POS_WR: begin
                        if (w_rotor_ok) begin
                            r_pos[RW'(r_rotor)] <= r_entry;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == rcm_pkg::OP_EMIT && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == rcm_pkg::OP_EMIT && !w_out_busy) begin
            r_out_letter <= w_pb_val;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_letter = r_out_letter;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// testbench for rotor_cipher_machine_unit: a cycle-free model of the rotor machine predicts
// every cipher letter, which is checked against the result stream; depends on rcm_pkg
module tb;

    localparam int ALPHA      = rcm_pkg::ALPHA;
    localparam int MAX_ROTORS = rcm_pkg::MAX_ROTORS;
    localparam logic [2:0] ACT_ENCRYPT  = rcm_pkg::ACT_ENCRYPT;
    localparam logic [2:0] ACT_PLUG_SWP = rcm_pkg::ACT_PLUG_SWP;
    localparam logic [2:0] ACT_WIRE_WR  = rcm_pkg::ACT_WIRE_WR;
    localparam logic [2:0] ACT_SET_POS  = rcm_pkg::ACT_SET_POS;
    localparam logic [2:0] ACT_REFL_WR  = rcm_pkg::ACT_REFL_WR;
    localparam logic [2:0] ACT_PLUG_RST = rcm_pkg::ACT_PLUG_RST;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int HALF_PERIOD  = 6;
    localparam int SETTLE       = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;

    // machine state as the predictor sees it
    logic [4:0] plug_map [ALPHA];
    logic [4:0] wiring   [MAX_ROTORS][ALPHA];
    logic [4:0] inverse  [MAX_ROTORS][ALPHA];
    logic [4:0] reflect  [ALPHA];
    logic [4:0] offset   [MAX_ROTORS];
    logic [3:0] model_rotor_count;

    logic [4:0] cipher_queue [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    bit         hold_request = 1'b0;

    rotor_cipher_machine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // state after reset
    function automatic void reset_machine();
        for (int i = 0; i < ALPHA; i++) begin
            plug_map[i] = 5'(i);
            reflect[i]  = '0;
            for (int r = 0; r < MAX_ROTORS; r++) begin
                wiring[r][i]  = '0;
                inverse[r][i] = '0;
            end
        end
        for (int r = 0; r < MAX_ROTORS; r++) offset[r] = '0;
        model_rotor_count = 4'd3;
    endfunction

    // apply one request to the machine, queue the cipher letter of an encrypt
    function automatic void advance_machine(input logic [2:0] act, input logic [2:0] rot,
                                            input logic [4:0] ent, input logic [4:0] ltr,
                                            input logic [4:0] sec);
        int e, a, b, used, x, p, j;
        logic [4:0] t;
        bit carry;
        e = ent % ALPHA;
        a = ltr % ALPHA;
        b = sec % ALPHA;
        used = (model_rotor_count < MAX_ROTORS) ? model_rotor_count : MAX_ROTORS;
        case (act)
            ACT_ENCRYPT: begin
                // odometer stepping, carry out of the last rotor is lost
                carry = 1'b1;
                for (j = 0; j < used; j++) begin
                    if (carry) begin
                        if (offset[j] == ALPHA - 1) begin
                            offset[j] = '0;
                        end else begin
                            offset[j] = offset[j] + 5'd1;
                            carry = 1'b0;
                        end
                    end
                end
                x = plug_map[a];
                for (j = 0; j < used; j++) begin
                    p = offset[j];
                    x = (inverse[j][(x + p) % ALPHA] + ALPHA - p) % ALPHA;
                end
                x = reflect[x];
                for (j = used - 1; j >= 0; j--) begin
                    p = offset[j];
                    x = (wiring[j][(x + p) % ALPHA] + ALPHA - p) % ALPHA;
                end
                x = plug_map[x];
                cipher_queue = {cipher_queue, 5'(x)};
            end
            ACT_PLUG_SWP: begin
                t = plug_map[a];
                plug_map[a] = plug_map[b];
                plug_map[b] = t;
            end
            ACT_WIRE_WR: begin
                wiring[rot][e]  = 5'(a);
                inverse[rot][a] = 5'(e);
            end
            ACT_SET_POS:  offset[rot] = 5'(e);
            ACT_REFL_WR:  reflect[a] = 5'(e);
            ACT_PLUG_RST: for (j = 0; j < ALPHA; j++) plug_map[j] = 5'(j);
            default: ;
        endcase
    endfunction

    // offer one request in bursts with random gaps, predict on acceptance
    task automatic send_request(input logic [2:0] act, input logic [2:0] rot,
                                input logic [4:0] ent, input logic [4:0] ltr,
                                input logic [4:0] sec);
        int gap;
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 4);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {6'b0, sec, ltr, ent, rot};
        do @(posedge i_clk); while (!o_s_tready);
        advance_machine(act, rot, ent, ltr, sec);
    endtask

    // stop offering, wait for every letter, then let any load finish
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_rotor_count(input logic [3:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_rotor_count = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // fill reflector and all rotor tables with permutations so no read hits an unwritten entry
    task automatic load_tables();
        int perm [ALPHA];
        int k, tmp;
        for (int r = 0; r <= MAX_ROTORS; r++) begin
            for (int i = 0; i < ALPHA; i++) perm[i] = i;
            for (int i = ALPHA - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[k];
                perm[k] = tmp;
            end
            for (int i = 0; i < ALPHA; i++) begin
                if (r == MAX_ROTORS)
                    send_request(ACT_REFL_WR, 3'($urandom_range(0, 7)), 5'(perm[i]), 5'(i),
                                 5'($urandom_range(0, 31)));
                else
                    send_request(ACT_WIRE_WR, 3'(r), 5'(i), 5'(perm[i]),
                                 5'($urandom_range(0, 31)));
            end
        end
    endtask

    // positions of the three rotors in use at the last letter: carry ripples through and falls off the end
    task automatic test_carry_ripple();
        for (int r = 0; r < 3; r++) send_request(ACT_SET_POS, 3'(r), 5'd25, 5'd0, 5'd0);
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd0, 5'd0);
        send_request(ACT_ENCRYPT, 3'd7, 5'd31, 5'd25, 5'd31);
    endtask

    // letters and indexes above the alphabet fold back into it
    task automatic test_letter_folding();
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd26, 5'd0);
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd31, 5'd0);
        send_request(ACT_SET_POS, 3'd7, 5'd31, 5'd0, 5'd0);
        send_request(ACT_PLUG_SWP, 3'd0, 5'd0, 5'd30, 5'd2);
    endtask

    // swap with itself, swap the ends of the alphabet, then back to identity
    task automatic test_plugboard();
        send_request(ACT_PLUG_SWP, 3'd0, 5'd0, 5'd1, 5'd1);
        send_request(ACT_PLUG_SWP, 3'd0, 5'd0, 5'd0, 5'd25);
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd0, 5'd0);
        send_request(ACT_PLUG_RST, 3'd0, 5'd0, 5'd0, 5'd0);
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd0, 5'd0);
    endtask

    // overwrites that break the permutations of a rotor and of the reflector
    task automatic test_table_overwrite();
        send_request(ACT_WIRE_WR, 3'd0, 5'd3, 5'd28, 5'd0);
        send_request(ACT_REFL_WR, 3'd0, 5'd30, 5'd27, 5'd0);
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd2, 5'd0);
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd3, 5'd0);
    endtask

    // spare action codes change nothing and give no letter
    task automatic test_spare_actions();
        send_request(ACT_SPARE_6, 3'd7, 5'd31, 5'd31, 5'd31);
        send_request(ACT_SPARE_7, 3'd5, 5'd12, 5'd9, 5'd20);
        send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'd9, 5'd0);
    endtask

    // no rotors: plugboard, reflector, plugboard
    task automatic test_zero_rotors();
        write_rotor_count(4'd0);
        for (int i = 0; i < 4; i++)
            send_request(ACT_ENCRYPT, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                         5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        write_rotor_count(4'd3);
    endtask

    // result side held off while encrypt requests keep coming
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (30)
            send_request(ACT_ENCRYPT, 3'd0, 5'd0, 5'($urandom_range(0, 31)), 5'd0);
        gaps_on = 1'b1;
        drain();
    endtask

    // one random request, mostly encrypts; spare actions do not count
    task automatic random_request(output bit counted);
        int r;
        logic [2:0] act;
        logic [4:0] ent;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < 60)      act = ACT_ENCRYPT;
        else if (r < 70) act = ACT_PLUG_SWP;
        else if (r < 78) act = ACT_WIRE_WR;
        else if (r < 86) act = ACT_SET_POS;
        else if (r < 91) act = ACT_REFL_WR;
        else if (r < 94) act = ACT_PLUG_RST;
        else begin
            act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7;
            counted = 1'b0;
        end
        ent = ($urandom_range(0, 3) == 0) ? 5'd25 : 5'($urandom_range(0, 31));
        send_request(act, 3'($urandom_range(0, 7)), ent, 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)));
    endtask

    // random traffic under one rotor count, positions preset at random, often at the last letter
    task automatic test_random_phase(input logic [3:0] count);
        int done;
        bit counted;
        write_rotor_count(count);
        for (int r = 0; r < MAX_ROTORS; r++)
            send_request(ACT_SET_POS, 3'(r),
                         ($urandom_range(0, 1) != 0) ? 5'd25 : 5'($urandom_range(0, 31)),
                         5'd0, 5'd0);
        gaps_on = ($urandom_range(0, 3) != 0);
        done = 0;
        while (done < PHASE_ITEMS) begin
            random_request(counted);
            if (counted) done++;
            if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
        end
    endtask

    // result receiver: stall patterns in segments, or one long hold on request
    initial begin
        int mode, seg, period;
        i_m_tready = 1'b0;
        forever begin
            if (hold_request) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                seg = $urandom_range(10, 150);
                period = $urandom_range(3, 9);
                for (int k = 0; k < seg && !hold_request; k++) begin
                    @(negedge i_clk);
                    case (mode)
                        0: i_m_tready <= 1'b1;
                        1: i_m_tready <= ($urandom_range(0, 9) < 7);
                        2: i_m_tready <= ((k % period) < period - 2);
                        default: i_m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // compare each letter with the oldest prediction
    always @(posedge i_clk) begin : check_results
        logic [4:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cipher_queue.size() == 0) begin
                $display("%0t: unexpected cipher letter: expected none, actual %0d",
                         $time, o_m_tdata[4:0]);
                mismatches++;
            end else begin
                want = cipher_queue.pop_front();
                if (o_m_tdata[4:0] !== want) begin
                    $display("%0t: cipher_letter mismatch: expected %0d, actual %0d",
                             $time, want, o_m_tdata[4:0]);
                    mismatches++;
                end
            end
        end
    end

    // no request, letter or register write accepted for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        reset_machine();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_tables();
        test_carry_ripple();
        test_letter_folding();
        test_plugboard();
        test_table_overwrite();
        test_spare_actions();
        test_zero_rotors();
        test_backpressure();
        test_random_phase(4'd1);
        test_random_phase(4'd8);
        test_random_phase(4'd15);
        test_random_phase(4'd0);
        test_random_phase(4'd2);
        test_random_phase(4'($urandom_range(0, 15)));
        test_random_phase(4'd3);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && cipher_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
